// File: design/i2a_pkg.sv
// Shared constants and types for the integer to ASCII radix unit.
`default_nettype none

package i2a_pkg;

    // default width of the converted value
    localparam int VALUE_WIDTH_DEF = 32;

    // depth of the queue between the front end and the converter
    localparam int QUEUE_DEPTH = 2;

    // conversion kinds as coded on req_type
    localparam logic [1:0] KIND_SDEC = 2'd0;
    localparam logic [1:0] KIND_UDEC = 2'd1;
    localparam logic [1:0] KIND_SOCT = 2'd2;
    localparam logic [1:0] KIND_SHEX = 2'd3;

    // ASCII codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // classification of one queued word
    typedef struct packed {
        logic [1:0] kind;
        logic       neg;
    } i2a_cls_t;

endpackage

`default_nettype wire

// File: design/i2a_front.sv
// Front end: takes words, splits sign from magnitude and queues them.
`default_nettype none

module i2a_front #(
    parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [VALUE_WIDTH-1:0] value_bits,
    input  wire logic [1:0]             req_type,
    output logic                        head_valid,
    output logic [VALUE_WIDTH-1:0]      head_mag,
    output i2a_pkg::i2a_cls_t           head_cls,
    input  wire logic                   head_pop
);

    localparam int DEPTH = i2a_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [VALUE_WIDTH-1:0] mag_mem [DEPTH];
    i2a_pkg::i2a_cls_t      cls_mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic                   wr_en;
    logic                   rd_en;
    logic                   in_neg;
    logic [VALUE_WIDTH-1:0] in_mag;
    i2a_pkg::i2a_cls_t      in_cls;

    // unsigned decimal never carries a sign; 2^(W-1) negates to itself
    assign in_neg = (req_type != i2a_pkg::KIND_UDEC) && value_bits[VALUE_WIDTH-1];
    assign in_mag = in_neg ? (~value_bits + 1'b1) : value_bits;

    always_comb
    begin
        in_cls.kind = req_type;
        in_cls.neg  = in_neg;
    end

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign wr_en      = push && !full;
    assign rd_en      = head_pop && head_valid;
    assign head_mag   = mag_mem[rd_ptr_reg];
    assign head_cls   = cls_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mag_mem[wr_ptr_reg] <= in_mag;
            cls_mem[wr_ptr_reg] <= in_cls;
        end
    end

endmodule

`default_nettype wire

// File: design/i2a_back.sv
// Back end: digit conversion and character output register.
`default_nettype none

module i2a_back #(
    parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   head_valid,
    input  wire logic [VALUE_WIDTH-1:0] head_mag,
    input  wire i2a_pkg::i2a_cls_t      head_cls,
    output logic                        head_pop,
    output logic                        empty,
    input  wire logic                   pop,
    output logic [7:0]                  ascii_char,
    output logic                        last_char
);

    // magnitude padded to whole nibbles, four shift-add-3 steps per cycle
    localparam int MAG_W = ((VALUE_WIDTH + 3) / 4) * 4;
    localparam int STEPS = MAG_W / 4;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int NDEC  = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int NDIG  = (VALUE_WIDTH + 2) / 3;
    localparam int IDX_W = $clog2(NDIG);

    typedef enum logic [1:0] {
        S_IDLE,
        S_BCD,
        S_TOP,
        S_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [MAG_W-1:0]    mag_reg, mag_next;
    logic [4*NDEC-1:0]   bcd_reg, bcd_next;
    logic [3:0]          dig_reg [NDIG];
    logic [3:0]          dig_next [NDIG];
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                neg_reg, neg_next;
    logic                sign_reg, sign_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_char_reg, out_char_next;
    logic                out_last_reg, out_last_next;

    logic [4*NDEC-1:0]   dab_bcd;
    logic [MAG_W-1:0]    dab_mag;
    logic [4*NDIG-1:0]   hex_vec;
    logic [3*NDIG-1:0]   oct_vec;
    logic [4*NDIG-1:0]   dec_vec;
    logic [IDX_W-1:0]    top_idx;
    logic [3:0]          cur_dig;
    logic [7:0]          cur_char;
    logic                slot_free;

    assign empty      = !out_valid_reg;
    assign ascii_char = out_char_reg;
    assign last_char  = out_last_reg;
    assign slot_free  = !out_valid_reg || pop;
    assign head_pop   = (state_reg == S_IDLE) && head_valid;

    assign hex_vec = (4*NDIG)'(head_mag);
    assign oct_vec = (3*NDIG)'(head_mag);
    assign dec_vec = (4*NDIG)'(dab_bcd);

    // double dabble: add 3 to digits of 5 or more, then shift in one bit
    always_comb
    begin
        dab_bcd = bcd_reg;
        dab_mag = mag_reg;
        for (int s = 0; s < 4; s++)
        begin
            for (int d = 0; d < NDEC; d++)
            begin
                if (dab_bcd[4*d +: 4] >= 4'd5)
                begin
                    dab_bcd[4*d +: 4] = dab_bcd[4*d +: 4] + 4'd3;
                end
            end
            dab_bcd = {dab_bcd[4*NDEC-2:0], dab_mag[MAG_W-1]};
            dab_mag = {dab_mag[MAG_W-2:0], 1'b0};
        end
    end

    // most significant nonzero digit, zero if all digits are zero
    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < NDIG; i++)
        begin
            if (dig_reg[i] != 4'd0)
            begin
                top_idx = IDX_W'(i);
            end
        end
    end

    assign cur_dig  = dig_reg[idx_reg];
    assign cur_char = (cur_dig < 4'd10) ? (i2a_pkg::CHAR_ZERO + {4'd0, cur_dig})
                                        : (i2a_pkg::CHAR_A + {4'd0, cur_dig - 4'd10});

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        dig_next       = dig_reg;
        idx_next       = idx_reg;
        neg_next       = neg_reg;
        sign_next      = sign_reg;
        out_valid_next = out_valid_reg && !pop;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    neg_next = head_cls.neg;
                    if (head_cls.kind inside {i2a_pkg::KIND_SDEC, i2a_pkg::KIND_UDEC})
                    begin
                        mag_next   = MAG_W'(head_mag);
                        bcd_next   = '0;
                        cnt_next   = '0;
                        state_next = S_BCD;
                    end
                    else
                    begin
                        for (int i = 0; i < NDIG; i++)
                        begin
                            if (head_cls.kind == i2a_pkg::KIND_SHEX)
                            begin
                                dig_next[i] = hex_vec[4*i +: 4];
                            end
                            else
                            begin
                                dig_next[i] = {1'b0, oct_vec[3*i +: 3]};
                            end
                        end
                        state_next = S_TOP;
                    end
                end
            end
            S_BCD:
            begin
                bcd_next = dab_bcd;
                mag_next = dab_mag;
                cnt_next = CNT_W'(cnt_reg + 1'b1);
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    for (int i = 0; i < NDIG; i++)
                    begin
                        dig_next[i] = dec_vec[4*i +: 4];
                    end
                    state_next = S_TOP;
                end
            end
            S_TOP:
            begin
                idx_next   = top_idx;
                sign_next  = neg_reg;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (sign_reg)
                    begin
                        out_char_next = i2a_pkg::CHAR_MINUS;
                        out_last_next = 1'b0;
                        sign_next     = 1'b0;
                    end
                    else
                    begin
                        out_char_next = cur_char;
                        out_last_next = (idx_reg == '0);
                        if (idx_reg == '0)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            idx_next = IDX_W'(idx_reg - 1'b1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            mag_reg       <= '0;
            bcd_reg       <= '0;
            idx_reg       <= '0;
            neg_reg       <= 1'b0;
            sign_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            out_last_reg  <= 1'b0;
            for (int i = 0; i < NDIG; i++)
            begin
                dig_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            mag_reg       <= mag_next;
            bcd_reg       <= bcd_next;
            idx_reg       <= idx_next;
            neg_reg       <= neg_next;
            sign_reg      <= sign_next;
            out_valid_reg <= out_valid_next;
            out_char_reg  <= out_char_next;
            out_last_reg  <= out_last_next;
            dig_reg       <= dig_next;
        end
    end

endmodule

`default_nettype wire

// File: design/integer_to_ascii_radix_unit.sv
// Top level of the integer to ASCII radix unit.
`default_nettype none

// Converts one VALUE_WIDTH-bit word to ASCII text, most significant character
// first, one output word per character, with last_char set on the final one.
// req_type selects signed decimal, unsigned decimal, signed octal or signed
// hex (upper case). Negative signed values get a leading '-' followed by the
// magnitude; the most negative value prints as 2^(VALUE_WIDTH-1). Zero prints
// as a single '0'. Both sides are queue-like: push/full in, empty/pop out.
// The front end classifies words into a two-entry queue, so the next word can
// be pushed while the converter is busy. The converter handles one word at a
// time: it first loads the word; decimal then runs a shift-add-3 BCD pass over
// the magnitude nibbles; the leading digit is then found; then one character
// per cycle goes out when the output register is free.

module integer_to_ascii_radix_unit #(
    parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [VALUE_WIDTH-1:0] value_bits,
    input  wire logic [1:0]             req_type,
    output logic                        empty,
    input  wire logic                   pop,
    output logic [7:0]                  ascii_char,
    output logic                        last_char
);

    // queue head between front end and converter
    logic                   head_valid;
    logic                   head_pop;
    logic [VALUE_WIDTH-1:0] head_mag;
    i2a_pkg::i2a_cls_t      head_cls;

    i2a_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .value_bits(value_bits),
        .req_type  (req_type),
        .head_valid(head_valid),
        .head_mag  (head_mag),
        .head_cls  (head_cls),
        .head_pop  (head_pop)
    );

    i2a_back #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_valid(head_valid),
        .head_mag  (head_mag),
        .head_cls  (head_cls),
        .head_pop  (head_pop),
        .empty     (empty),
        .pop       (pop),
        .ascii_char(ascii_char),
        .last_char (last_char)
    );

endmodule

`default_nettype wire
